>>> hdl/bba_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bba_pkg
// Shared types, constants and helpers for the buddy block allocator.
// ----------------------------------------------------------------------------
package bba_pkg;

   // pool size default and register reset
   localparam int POOL_UNITS_DEF   = 1024;
   localparam int POOL_ORDER_RESET = 10;

   // field widths
   localparam int CMD_W    = 1;
   localparam int SIZE_W   = 11;
   localparam int START_W  = 10;
   localparam int STATUS_W = 2;
   localparam int CFG_W    = 4;
   localparam int ORD_W    = 5;
   localparam int K_W      = 4;

   // register file
   localparam int PADDR_W = 3;
   localparam int PDATA_W = 32;
   localparam logic [PADDR_W-3:0] REG_POOL_ORDER = '0;

   // command codes
   localparam logic [CMD_W-1:0] CMD_ALLOC = 1'b0;
   localparam logic [CMD_W-1:0] CMD_FREE  = 1'b1;

   // status codes
   localparam logic [STATUS_W-1:0] ST_DONE     = 2'd0;
   localparam logic [STATUS_W-1:0] ST_NO_SPACE = 2'd1;
   localparam logic [STATUS_W-1:0] ST_BAD_FREE = 2'd2;

   // one block table entry: a block starts here, is taken, and its order
   typedef struct packed {
      logic             valid;
      logic             used;
      logic [ORD_W-1:0] ord;
   } entry_type;

   typedef enum logic [3:0] {
      S_CLEAR,
      S_IDLE,
      S_SCAN_RD,
      S_SCAN_EV,
      S_SPLIT,
      S_FREE_EV,
      S_MERGE_EV,
      S_FREE_WB,
      S_OUT
   } state_type;

   // smallest order k with 2^k >= req, zero counting as one
   function automatic logic [K_W-1:0] round_order(input logic [SIZE_W-1:0] req);
      logic [SIZE_W-1:0] m;
      logic [K_W-1:0]    k;
      m = (req == '0) ? '0 : req - SIZE_W'(1);
      k = '0;
      for (int i = 0; i < SIZE_W; i++) begin
         if (m[i]) begin
            k = K_W'(i + 1);
         end
      end
      return k;
   endfunction

endpackage

>>> hdl/bba_store.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bba_store
// Block table memory: one write port, one read port, registered read data.
// ----------------------------------------------------------------------------
module bba_store
   import bba_pkg::*;
#(
   parameter int POOL_UNITS = POOL_UNITS_DEF,
   parameter int AW         = $clog2(POOL_UNITS)
) (
   input  logic            clock,
   input  logic            rd_en,
   input  logic [AW-1:0]   rd_addr,
   output entry_type       rd_data,
   input  logic            wr_en,
   input  logic [AW-1:0]   wr_addr,
   input  entry_type       wr_data
);

   entry_type mem [POOL_UNITS];

   // write port
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
   end

   // read port, registered data
   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data <= mem[rd_addr];
      end
   end

endmodule

>>> hdl/bba_ctrl.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bba_ctrl
// Sequencer: table clear, block walk, split, free and merge, result register.
// ----------------------------------------------------------------------------
module bba_ctrl
   import bba_pkg::*;
#(
   parameter int POOL_UNITS = POOL_UNITS_DEF,
   parameter int AW         = $clog2(POOL_UNITS)
) (
   input  logic                clock,
   input  logic                reset,
   input  logic                cfg_load,
   input  logic [ORD_W-1:0]    po,
   input  logic                req_valid,
   output logic                req_stall,
   input  logic [CMD_W-1:0]    req_command,
   input  logic [SIZE_W-1:0]   req_request_size,
   input  logic [START_W-1:0]  req_block_start,
   output logic                rsp_valid,
   input  logic                rsp_stall,
   output logic [STATUS_W-1:0] rsp_status,
   output logic [START_W-1:0]  rsp_granted_start,
   output logic [SIZE_W-1:0]   rsp_granted_size,
   output logic                rd_en,
   output logic [AW-1:0]       rd_addr,
   input  entry_type           rd_data,
   output logic                wr_en,
   output logic [AW-1:0]       wr_addr,
   output entry_type           wr_data
);

   localparam int PW = AW + 1;
   localparam int CW = (PW > START_W + 1) ? PW : START_W + 1;

   state_type           state_ff, state_in;
   logic [PW-1:0]       clr_ff, clr_in;
   logic [K_W-1:0]      k_ff, k_in;
   logic [PW-1:0]       walk_ff, walk_in;
   logic                found_ff, found_in;
   logic [AW-1:0]       best_ff, best_in;
   logic [ORD_W-1:0]    bord_ff, bord_in;
   logic [AW-1:0]       cur_ff, cur_in;
   logic [ORD_W-1:0]    ord_ff, ord_in;
   logic [STATUS_W-1:0] pst_ff, pst_in;
   logic [START_W-1:0]  pstart_ff, pstart_in;
   logic [SIZE_W-1:0]   psz_ff, psz_in;
   logic                rsp_valid_ff, rsp_valid_in;
   logic [STATUS_W-1:0] rsp_status_ff, rsp_status_in;
   logic [START_W-1:0]  rsp_start_ff, rsp_start_in;
   logic [SIZE_W-1:0]   rsp_size_ff, rsp_size_in;

   logic [PW-1:0]       psize;
   logic [ORD_W-1:0]    k_ext;
   logic                cand;
   logic                f_n;
   logic [AW-1:0]       b_n;
   logic [ORD_W-1:0]    bo_n;
   logic [PW-1:0]       walk_nx;
   logic [AW-1:0]       buddy;
   logic [AW-1:0]       lo;
   logic [AW-1:0]       hi;
   logic [ORD_W-1:0]    ord_p1;
   logic [ORD_W-1:0]    bord_m1;

   assign psize = PW'(1) << po;
   assign k_ext = ORD_W'(k_ff);

   // block walk step: best fit among free blocks, lowest start on ties
   always_comb begin
      cand = rd_data.valid && !rd_data.used && (rd_data.ord >= k_ext) &&
             (!found_ff || (rd_data.ord < bord_ff));
      f_n  = found_ff || cand;
      b_n  = cand ? walk_ff[AW-1:0] : best_ff;
      bo_n = cand ? rd_data.ord : bord_ff;
      walk_nx = rd_data.valid ? walk_ff + (PW'(1) << rd_data.ord) : walk_ff + PW'(1);
   end

   // merge step helpers
   assign buddy   = cur_ff ^ AW'(PW'(1) << ord_ff);
   assign lo      = (cur_ff < buddy) ? cur_ff : buddy;
   assign hi      = (cur_ff < buddy) ? buddy : cur_ff;
   assign ord_p1  = ord_ff + ORD_W'(1);
   assign bord_m1 = bord_ff - ORD_W'(1);

   // next state and outputs
   always_comb begin
      state_in     = state_ff;
      clr_in       = clr_ff;
      k_in         = k_ff;
      walk_in      = walk_ff;
      found_in     = found_ff;
      best_in      = best_ff;
      bord_in      = bord_ff;
      cur_in       = cur_ff;
      ord_in       = ord_ff;
      pst_in       = pst_ff;
      pstart_in    = pstart_ff;
      psz_in       = psz_ff;
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      rsp_status_in = rsp_status_ff;
      rsp_start_in  = rsp_start_ff;
      rsp_size_in   = rsp_size_ff;
      req_stall    = 1'b1;
      rd_en        = 1'b0;
      rd_addr      = '0;
      wr_en        = 1'b0;
      wr_addr      = '0;
      wr_data      = '0;

      unique case (state_ff)
         S_CLEAR: begin
            // sweep the table, entry 0 gets the whole pool
            wr_en   = 1'b1;
            wr_addr = clr_ff[AW-1:0];
            wr_data = (clr_ff == '0) ? entry_type'{valid: 1'b1, used: 1'b0, ord: po}
                                     : entry_type'('0);
            clr_in  = clr_ff + PW'(1);
            if (clr_ff == PW'(POOL_UNITS - 1)) begin
               state_in = S_IDLE;
            end
         end
         S_IDLE: begin
            req_stall = 1'b0;
            if (req_valid) begin
               pst_in    = ST_DONE;
               pstart_in = '0;
               psz_in    = '0;
               if (req_command == CMD_ALLOC) begin
                  k_in     = round_order(req_request_size);
                  walk_in  = '0;
                  found_in = 1'b0;
                  state_in = S_SCAN_RD;
               end else if (CW'(req_block_start) >= CW'(psize)) begin
                  pst_in   = ST_BAD_FREE;
                  state_in = S_OUT;
               end else begin
                  cur_in   = AW'(req_block_start);
                  rd_en    = 1'b1;
                  rd_addr  = AW'(req_block_start);
                  state_in = S_FREE_EV;
               end
            end
         end
         S_SCAN_RD: begin
            rd_en    = 1'b1;
            rd_addr  = walk_ff[AW-1:0];
            state_in = S_SCAN_EV;
         end
         S_SCAN_EV: begin
            // fold one block, then fetch the next one while the walk is inside the pool
            found_in = f_n;
            best_in  = b_n;
            bord_in  = bo_n;
            walk_in  = walk_nx;
            if (walk_nx >= psize) begin
               if (!f_n) begin
                  pst_in   = ST_NO_SPACE;
                  state_in = S_OUT;
               end else begin
                  state_in = S_SPLIT;
               end
            end else begin
               rd_en   = 1'b1;
               rd_addr = walk_nx[AW-1:0];
            end
         end
         S_SPLIT: begin
            // halve, keeping the left half, until the order matches
            wr_en = 1'b1;
            if (bord_ff > k_ext) begin
               wr_addr = best_ff + AW'(PW'(1) << bord_m1);
               wr_data = '{valid: 1'b1, used: 1'b0, ord: bord_m1};
               bord_in = bord_m1;
            end else begin
               wr_addr   = best_ff;
               wr_data   = '{valid: 1'b1, used: 1'b1, ord: bord_ff};
               pst_in    = ST_DONE;
               pstart_in = START_W'(best_ff);
               psz_in    = SIZE_W'(12'(1) << k_ff);
               state_in  = S_OUT;
            end
         end
         S_FREE_EV: begin
            if (!rd_data.valid) begin
               pst_in   = ST_BAD_FREE;
               state_in = S_OUT;
            end else begin
               ord_in = rd_data.ord;
               if (rd_data.ord < po) begin
                  rd_en    = 1'b1;
                  rd_addr  = cur_ff ^ AW'(PW'(1) << rd_data.ord);
                  state_in = S_MERGE_EV;
               end else begin
                  state_in = S_FREE_WB;
               end
            end
         end
         S_MERGE_EV: begin
            // merge with a free buddy of equal order, drop the upper start
            if (rd_data.valid && !rd_data.used && (rd_data.ord == ord_ff)) begin
               wr_en   = 1'b1;
               wr_addr = hi;
               wr_data = '0;
               cur_in  = lo;
               ord_in  = ord_p1;
               if (ord_p1 < po) begin
                  rd_en   = 1'b1;
                  rd_addr = lo ^ AW'(PW'(1) << ord_p1);
               end else begin
                  state_in = S_FREE_WB;
               end
            end else begin
               state_in = S_FREE_WB;
            end
         end
         S_FREE_WB: begin
            wr_en    = 1'b1;
            wr_addr  = cur_ff;
            wr_data  = '{valid: 1'b1, used: 1'b0, ord: ord_ff};
            pst_in   = ST_DONE;
            state_in = S_OUT;
         end
         S_OUT: begin
            // hold until the result register is free
            if (!rsp_valid_ff || !rsp_stall) begin
               rsp_valid_in  = 1'b1;
               rsp_status_in = pst_ff;
               rsp_start_in  = pstart_ff;
               rsp_size_in   = psz_ff;
               state_in      = S_IDLE;
            end
         end
         default: begin
            state_in = S_CLEAR;
         end
      endcase

      // a register write restarts the sweep
      if (cfg_load) begin
         state_in = S_CLEAR;
         clr_in   = '0;
      end
   end

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_CLEAR;
         clr_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         clr_ff       <= clr_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      k_ff          <= k_in;
      walk_ff       <= walk_in;
      found_ff      <= found_in;
      best_ff       <= best_in;
      bord_ff       <= bord_in;
      cur_ff        <= cur_in;
      ord_ff        <= ord_in;
      pst_ff        <= pst_in;
      pstart_ff     <= pstart_in;
      psz_ff        <= psz_in;
      rsp_status_ff <= rsp_status_in;
      rsp_start_ff  <= rsp_start_in;
      rsp_size_ff   <= rsp_size_in;
   end

   assign rsp_valid         = rsp_valid_ff;
   assign rsp_status        = rsp_status_ff;
   assign rsp_granted_start = rsp_start_ff;
   assign rsp_granted_size  = rsp_size_ff;

   // same-entry read and write never overlap
   a_no_rw_overlap: assert property (@(posedge clock) disable iff (reset)
      (rd_en && wr_en) |-> (rd_addr != wr_addr))
      else $error("read and write to the same entry");

   // an accepted item leaves idle
   a_leave_idle: assert property (@(posedge clock) disable iff (reset)
      (req_valid && !req_stall && !cfg_load) |=> (state_ff != S_IDLE))
      else $error("item accepted but sequencer stayed idle");

   // no item taken during the sweep
   a_clear_stall: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_CLEAR) |-> req_stall)
      else $error("item taken during table clear");

   // failed results carry no grant
   a_fail_zero: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && (rsp_status != ST_DONE)) |->
      ((rsp_granted_size == '0) && (rsp_granted_start == '0)))
      else $error("failed result carries a grant");

endmodule

>>> hdl/buddy_block_allocator_unit.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// buddy_block_allocator_unit
// Buddy allocator over a pool of 2^pool_order units, one result per item.
// ----------------------------------------------------------------------------
// An allocate walks the current blocks from offset 0, one block per cycle
// through the block table's read port, then writes one table entry per
// split plus one to mark the block. A free reads the freed entry, then does
// one table read per merge. After reset and after every pool_order write
// the table is cleared, one entry a cycle, while req_stall stays high. A
// result waits in an output register while the next item is taken.
module buddy_block_allocator_unit
   import bba_pkg::*;
#(
   parameter int POOL_UNITS = POOL_UNITS_DEF
) (
   input  logic                clock,
   input  logic                reset,
   input  logic                req_valid,
   output logic                req_stall,
   input  logic [CMD_W-1:0]    req_command,
   input  logic [SIZE_W-1:0]   req_request_size,
   input  logic [START_W-1:0]  req_block_start,
   output logic                rsp_valid,
   input  logic                rsp_stall,
   output logic [STATUS_W-1:0] rsp_status,
   output logic [START_W-1:0]  rsp_granted_start,
   output logic [SIZE_W-1:0]   rsp_granted_size,
   input  logic                psel,
   input  logic                penable,
   input  logic                pwrite,
   input  logic [PADDR_W-1:0]  paddr,
   input  logic [PDATA_W-1:0]  pwdata,
   output logic [PDATA_W-1:0]  prdata,
   output logic                pready
);

   localparam int AW   = $clog2(POOL_UNITS);
   localparam int MAXO = $clog2(POOL_UNITS + 1) - 1;

   logic [CFG_W-1:0] pool_order_ff, pool_order_in;
   logic             cfg_load;
   logic [ORD_W-1:0] po;
   logic             rd_en;
   logic [AW-1:0]    rd_addr;
   entry_type        rd_data;
   logic             wr_en;
   logic [AW-1:0]    wr_addr;
   entry_type        wr_data;

   // register write decode
   assign pready   = 1'b1;
   assign cfg_load = psel && penable && pwrite &&
                     (paddr[PADDR_W-1:2] == REG_POOL_ORDER);
   assign pool_order_in = cfg_load ? pwdata[CFG_W-1:0] : pool_order_ff;
   assign prdata = (paddr[PADDR_W-1:2] == REG_POOL_ORDER) ?
                   PDATA_W'(pool_order_ff) : '0;

   always_ff @(posedge clock) begin
      if (reset) begin
         pool_order_ff <= CFG_W'(POOL_ORDER_RESET);
      end else begin
         pool_order_ff <= pool_order_in;
      end
   end

   // clamp the order to what the table holds
   assign po = (ORD_W'(pool_order_ff) > ORD_W'(MAXO)) ? ORD_W'(MAXO)
                                                       : ORD_W'(pool_order_ff);

   bba_store #(
      .POOL_UNITS (POOL_UNITS),
      .AW         (AW)
   ) u_store (
      .clock   (clock),
      .rd_en   (rd_en),
      .rd_addr (rd_addr),
      .rd_data (rd_data),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (wr_data)
   );

   bba_ctrl #(
      .POOL_UNITS (POOL_UNITS),
      .AW         (AW)
   ) u_ctrl (
      .clock             (clock),
      .reset             (reset),
      .cfg_load          (cfg_load),
      .po                (po),
      .req_valid         (req_valid),
      .req_stall         (req_stall),
      .req_command       (req_command),
      .req_request_size  (req_request_size),
      .req_block_start   (req_block_start),
      .rsp_valid         (rsp_valid),
      .rsp_stall         (rsp_stall),
      .rsp_status        (rsp_status),
      .rsp_granted_start (rsp_granted_start),
      .rsp_granted_size  (rsp_granted_size),
      .rd_en             (rd_en),
      .rd_addr           (rd_addr),
      .rd_data           (rd_data),
      .wr_en             (wr_en),
      .wr_addr           (wr_addr),
      .wr_data           (wr_data)
   );

endmodule
